// File: rtl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 package
// Shared types, initial chaining value and round functions of the hash engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int NUM_WORDS = 5;
  localparam int ROUNDS    = 80;

  // Index 0 holds H0.
  typedef logic [NUM_WORDS-1:0][31:0] hash_t;

  localparam hash_t IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                          32'hEFCDAB89, 32'h67452301};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  // Byte position where the 64-bit length field starts.
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic shift_en;   // shift one byte into the block
    logic start;      // begin compressing the block
    logic init_hash;  // return the chaining value to IV
  } core_cmd_t;

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      f = b ^ c ^ d;
    end else if (r < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) begin
      k = 32'h5A827999;
    end else if (r < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (r < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

endpackage

// File: rtl/sha1_core.sv
// ----------------------------------------------------------------------------
// SHA-1 compression core
// Holds the 512-bit block as a shift line, the chaining value and the round
// variables; runs one round per cycle and adds the result into the hash.
// ----------------------------------------------------------------------------
module sha1_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha1_pkg::core_cmd_t  cmd,
  input  logic [7:0]           byte_in,
  output sha1_pkg::hash_t      hash_out,
  output logic                 done
);

  logic [511:0]    blk_r;
  sha1_pkg::hash_t hash_r;
  logic [31:0]     a_r, b_r, c_r, d_r, e_r;
  logic [6:0]      round_r;
  logic            busy_r;
  logic            fin_r;

  logic [31:0] w0, w2, w8, w13, sched_x, sched, temp;

  // The oldest schedule word sits at the top of the shift line.
  assign w0      = blk_r[511:480];
  assign w2      = blk_r[447:416];
  assign w8      = blk_r[255:224];
  assign w13     = blk_r[95:64];
  assign sched_x = w13 ^ w8 ^ w2 ^ w0;
  assign sched   = {sched_x[30:0], sched_x[31]};

  assign temp = {a_r[26:0], a_r[31:27]} + sha1_pkg::round_f(round_r, b_r, c_r, d_r)
              + e_r + sha1_pkg::round_k(round_r) + w0;

  assign hash_out = hash_r;
  assign done     = fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      fin_r   <= 1'b0;
      round_r <= '0;
      hash_r  <= sha1_pkg::IV;
    end else begin
      fin_r <= 1'b0;
      if (cmd.start) begin
        busy_r  <= 1'b1;
        round_r <= '0;
      end else if (busy_r) begin
        round_r <= round_r + 7'd1;
        if (round_r == 7'(sha1_pkg::ROUNDS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
      if (cmd.init_hash) begin
        hash_r <= sha1_pkg::IV;
      end else if (fin_r) begin
        hash_r[0] <= hash_r[0] + a_r;
        hash_r[1] <= hash_r[1] + b_r;
        hash_r[2] <= hash_r[2] + c_r;
        hash_r[3] <= hash_r[3] + d_r;
        hash_r[4] <= hash_r[4] + e_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      blk_r <= {blk_r[503:0], byte_in};
    end else if (busy_r) begin
      blk_r <= {blk_r[479:0], sched};
    end
    if (cmd.start) begin
      a_r <= hash_r[0];
      b_r <= hash_r[1];
      c_r <= hash_r[2];
      d_r <= hash_r[3];
      e_r <= hash_r[4];
    end else if (busy_r) begin
      a_r <= temp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

endmodule

// File: rtl/sha1_hash_engine.sv
// In the idle state in_ready is high and any item is taken; a byte that fills
// the 64-byte block holds in_ready low while the core runs its 80 rounds and adds into the hash.
// A last item then inserts padding at one byte per cycle with one or two compressions,
// and the five digest words follow at one per cycle as out_ready allows.
// The single round unit holds input off while it compresses a block.
// Reset (synchronous, rst_n low) loads the initial hash and clears length and position.
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Gathers message bytes into blocks, pads the final block with the bit length
// and emits the five digest words.
// ----------------------------------------------------------------------------
module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha1_pkg::state_t    state_r, state_nxt;
  logic [5:0]          pos_r, pos_nxt;
  logic [63:0]         bit_cnt_r, bit_cnt_nxt;
  logic                last_pend_r, last_pend_nxt;
  logic                pad_first_r, pad_first_nxt;
  logic                pad_len_r, pad_len_nxt;
  logic                final_r, final_nxt;
  logic [2:0]          idx_r, idx_nxt;

  sha1_pkg::core_cmd_t cmd;
  logic [7:0]          byte_sel;
  logic [7:0]          len_byte;
  sha1_pkg::hash_t     hash;
  logic                core_done;
  logic                last_idx;

  sha1_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .byte_in  (byte_sel),
    .hash_out (hash),
    .done     (core_done)
  );

  assign last_idx = (idx_r == 3'(sha1_pkg::NUM_WORDS - 1));
  // Length bytes go out most significant first.
  assign len_byte = 8'(bit_cnt_r >> {~pos_r[2:0], 3'b000});

  // Next state and register updates.
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    bit_cnt_nxt   = bit_cnt_r;
    last_pend_nxt = last_pend_r;
    pad_first_nxt = pad_first_r;
    pad_len_nxt   = pad_len_r;
    final_nxt     = final_r;
    idx_nxt       = idx_r;
    case (state_r)
      sha1_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_byte_valid) begin
            pos_nxt     = pos_r + 6'd1;
            bit_cnt_nxt = bit_cnt_r + 64'd8;
          end
          if (in_last) begin
            last_pend_nxt = 1'b1;
            pad_first_nxt = 1'b1;
          end
          if (in_byte_valid && pos_r == sha1_pkg::LAST_POS) begin
            state_nxt = sha1_pkg::ST_COMP;
          end else if (in_last) begin
            state_nxt = sha1_pkg::ST_PAD;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        pos_nxt = pos_r + 6'd1;
        if (pad_first_r) begin
          pad_first_nxt = 1'b0;
          pad_len_nxt   = (pos_r < sha1_pkg::LEN_POS);
        end else if (pad_len_r && pos_r == sha1_pkg::LAST_POS) begin
          final_nxt = 1'b1;
        end
        if (pos_r == sha1_pkg::LAST_POS) begin
          state_nxt = sha1_pkg::ST_COMP;
        end
      end
      sha1_pkg::ST_COMP: begin
        if (core_done) begin
          pad_len_nxt = 1'b1;
          if (final_r) begin
            state_nxt = sha1_pkg::ST_OUT;
            idx_nxt   = '0;
          end else if (last_pend_r) begin
            state_nxt = sha1_pkg::ST_PAD;
          end else begin
            state_nxt = sha1_pkg::ST_IDLE;
          end
        end
      end
      sha1_pkg::ST_OUT: begin
        if (out_ready) begin
          if (last_idx) begin
            state_nxt     = sha1_pkg::ST_IDLE;
            last_pend_nxt = 1'b0;
            final_nxt     = 1'b0;
            bit_cnt_nxt   = '0;
            pos_nxt       = '0;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = sha1_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and core commands.
  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd.shift_en  = 1'b0;
    cmd.start     = 1'b0;
    cmd.init_hash = 1'b0;
    byte_sel      = in_data_byte;
    case (state_r)
      sha1_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.shift_en = in_valid && in_byte_valid;
      end
      sha1_pkg::ST_PAD: begin
        cmd.shift_en = 1'b1;
        if (pad_first_r) begin
          byte_sel = sha1_pkg::PAD_BYTE;
        end else if (pad_len_r && pos_r >= sha1_pkg::LEN_POS) begin
          byte_sel = len_byte;
        end else begin
          byte_sel = '0;
        end
      end
      sha1_pkg::ST_OUT: begin
        out_valid     = 1'b1;
        cmd.init_hash = out_ready && last_idx;
      end
      default: begin
      end
    endcase
    cmd.start = cmd.shift_en && (pos_r == sha1_pkg::LAST_POS);
  end

  assign out_digest_word = hash[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = last_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha1_pkg::ST_IDLE;
      pos_r       <= '0;
      bit_cnt_r   <= '0;
      last_pend_r <= 1'b0;
      pad_first_r <= 1'b0;
      pad_len_r   <= 1'b0;
      final_r     <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      last_pend_r <= last_pend_nxt;
      pad_first_r <= pad_first_nxt;
      pad_len_r   <= pad_len_nxt;
      final_r     <= final_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule

// File: rtl/sha1_checker.sv
// ----------------------------------------------------------------------------
// SHA-1 port checker
// Watches the top-level ports of the hash engine over time.
// ----------------------------------------------------------------------------
module sha1_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_byte_valid,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  // A stalled digest word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word)
      && $stable(out_word_index))
    else $error("digest item changed while stalled");

  // The engine never takes input while it emits the digest.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready during digest output");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_word |=> out_valid
      && out_word_index == 3'($past(out_word_index) + 3'd1))
    else $error("digest words out of order");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'(sha1_pkg::NUM_WORDS - 1))))
    else $error("last word flag mismatch");

  // An idle item changes nothing, so the engine stays ready.
  a_idle_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_byte_valid && !in_last |=> in_ready)
    else $error("idle item stalled the engine");

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_byte_valid   (in_byte_valid),
  .in_last         (in_last),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_digest_word (out_digest_word),
  .out_word_index  (out_word_index),
  .out_last_word   (out_last_word)
);
